@@ rtl/core/pcl_pkg.sv @@
// Package for the press count code lock: phase codes, register indexes,
// tick counter sizing and the limited configuration struct. No dependencies.
`default_nettype none

package pcl_pkg;

    // Tick counter width and its saturation value
    localparam int TICK_W = 16;
    localparam logic [31:0] TICK_MAX32 = 32'hFFFF_FFFF >> (32 - TICK_W);
    localparam logic [TICK_W-1:0] TICK_MAX = TICK_MAX32[TICK_W-1:0];

    // Configuration port sizing
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_WINDOW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TO_LOCK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_HALF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUICK_HALF   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAIL_BLINKS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OK_BLINKS    = 3'd7;

    // Lock phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ENTER = 3'd1,
        PH_FAIL  = 3'd2,
        PH_OK    = 3'd3,
        PH_OPEN  = 3'd4,
        PH_PAUSE = 3'd5
    } t_phase;

    // Configuration after zero and range limiting
    typedef struct packed {
        logic [7:0]        press_target;
        logic [TICK_W-1:0] entry_window;
        logic [TICK_W-1:0] hold_to_lock;
        logic [7:0]        debounce;
        logic [TICK_W-1:0] slow_half;
        logic [TICK_W-1:0] quick_half;
        logic [4:0]        fail_total;
        logic [4:0]        ok_total;
    } t_cfg;

    // Map a time register to a tick limit: zero acts as one, clamp to max
    function automatic logic [TICK_W-1:0] tick_limit(input logic [15:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v == 16'd0) begin
            return TICK_W'(1);
        end else if (v32 > TICK_MAX32) begin
            return TICK_MAX;
        end
        return v32[TICK_W-1:0];
    endfunction

    // Saturating tick increment
    function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] v);
        if (v != TICK_MAX) begin
            return v + TICK_W'(1);
        end
        return v;
    endfunction

    // Blink halves for a blink count: zero acts as one
    function automatic logic [4:0] blink_total(input logic [3:0] n);
        if (n == 4'd0) begin
            return 5'd2;
        end
        return {n, 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pcl_cfg.sv @@
// Configuration registers of the press count code lock and their limiting.
// Depends on pcl_pkg.
`default_nettype none

module pcl_cfg
    import pcl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    logic [7:0]  r_press_target;
    logic [15:0] r_entry_window;
    logic [15:0] r_hold_to_lock;
    logic [7:0]  r_debounce;
    logic [15:0] r_slow_half;
    logic [15:0] r_quick_half;
    logic [3:0]  r_fail_blinks;
    logic [3:0]  r_ok_blinks;

    // Write one register per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_target <= 8'd5;
            r_entry_window <= 16'd5000;
            r_hold_to_lock <= 16'd3000;
            r_debounce     <= 8'd20;
            r_slow_half    <= 16'd500;
            r_quick_half   <= 16'd200;
            r_fail_blinks  <= 4'd10;
            r_ok_blinks    <= 4'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PRESS_TARGET: r_press_target <= i_cfg_wdata[7:0];
                REG_ENTRY_WINDOW: r_entry_window <= i_cfg_wdata;
                REG_HOLD_TO_LOCK: r_hold_to_lock <= i_cfg_wdata;
                REG_DEBOUNCE:     r_debounce     <= i_cfg_wdata[7:0];
                REG_SLOW_HALF:    r_slow_half    <= i_cfg_wdata;
                REG_QUICK_HALF:   r_quick_half   <= i_cfg_wdata;
                REG_FAIL_BLINKS:  r_fail_blinks  <= i_cfg_wdata[3:0];
                REG_OK_BLINKS:    r_ok_blinks    <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Limit zero and oversize values
    always_comb begin
        o_cfg.press_target = r_press_target;
        o_cfg.entry_window = tick_limit(r_entry_window);
        o_cfg.hold_to_lock = tick_limit(r_hold_to_lock);
        o_cfg.debounce     = (r_debounce == 8'd0) ? 8'd1 : r_debounce;
        o_cfg.slow_half    = tick_limit(r_slow_half);
        o_cfg.quick_half   = tick_limit(r_quick_half);
        o_cfg.fail_total   = blink_total(r_fail_blinks);
        o_cfg.ok_total     = blink_total(r_ok_blinks);
    end

endmodule

`default_nettype wire

@@ rtl/core/pcl_core.sv @@
// Lock state and one tick of debounce, phase and LED logic.
// Depends on pcl_pkg.
`default_nettype none

module pcl_core
    import pcl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic i_key,
    input  t_cfg      i_cfg,
    output logic      o_led,
    output t_phase    o_phase
);

    t_phase            r_phase,      n_phase;
    logic              r_key_stable, n_key_stable;
    logic [7:0]        r_db_cnt,     n_db_cnt;
    logic [TICK_W-1:0] r_ticks,      n_ticks;
    logic [TICK_W-1:0] r_hold,       n_hold;
    logic [7:0]        r_tally,      n_tally;
    logic [4:0]        r_blink,      n_blink;

    logic              press;
    logic              release_k;
    logic [7:0]        db_inc;
    logic [TICK_W-1:0] ticks_inc;
    logic [TICK_W-1:0] hold_inc;
    logic [4:0]        blink_inc;
    logic [4:0]        blink_lim;

    assign db_inc    = r_db_cnt + 8'd1;
    assign ticks_inc = tick_inc(r_ticks);
    assign hold_inc  = tick_inc(r_hold);
    assign blink_inc = r_blink + 5'd1;
    assign blink_lim = (r_phase == PH_FAIL) ? i_cfg.fail_total : i_cfg.ok_total;

    // Next state for one tick
    always_comb begin
        n_phase      = r_phase;
        n_key_stable = r_key_stable;
        n_db_cnt     = 8'd0;
        n_ticks      = r_ticks;
        n_hold       = r_hold;
        n_tally      = r_tally;
        n_blink      = r_blink;
        press        = 1'b0;
        release_k    = 1'b0;

        // Debounce the raw level
        if (i_key != r_key_stable) begin
            if (db_inc >= i_cfg.debounce) begin
                n_key_stable = i_key;
                press        = i_key;
                release_k    = !i_key;
            end else begin
                n_db_cnt = db_inc;
            end
        end

        unique case (r_phase)
            PH_ENTER: begin
                if (!r_blink[0]) begin
                    // wait for the first release to open the window
                    if (release_k) begin
                        n_blink = 5'd1;
                        n_ticks = '0;
                    end
                end else begin
                    if (release_k && r_tally != 8'hFF) begin
                        n_tally = r_tally + 8'd1;
                    end
                    n_ticks = ticks_inc;
                    if (ticks_inc >= i_cfg.entry_window) begin
                        n_phase = (n_tally == i_cfg.press_target) ? PH_OK : PH_FAIL;
                        n_ticks = '0;
                        n_blink = '0;
                        n_hold  = '0;
                    end
                end
            end
            PH_FAIL, PH_OK: begin
                n_ticks = ticks_inc;
                if (ticks_inc >= i_cfg.quick_half) begin
                    n_ticks = '0;
                    n_blink = blink_inc;
                    if (blink_inc >= blink_lim) begin
                        n_phase = (r_phase == PH_FAIL) ? PH_IDLE : PH_OPEN;
                        n_blink = '0;
                        n_hold  = '0;
                    end
                end
            end
            PH_OPEN: begin
                if (n_key_stable) begin
                    n_hold = hold_inc;
                    if (hold_inc >= i_cfg.hold_to_lock) begin
                        n_phase = PH_PAUSE;
                        n_ticks = '0;
                        n_blink = '0;
                        n_hold  = '0;
                    end
                end else begin
                    n_hold = '0;
                end
            end
            PH_PAUSE: begin
                n_ticks = ticks_inc;
                if (ticks_inc >= i_cfg.quick_half) begin
                    n_phase = PH_IDLE;
                    n_ticks = '0;
                    n_blink = '0;
                    n_hold  = '0;
                end
            end
            PH_IDLE: begin
                if (press) begin
                    n_phase = PH_ENTER;
                    n_ticks = '0;
                    n_blink = '0;
                    n_hold  = '0;
                    n_tally = 8'd1;
                end else begin
                    n_ticks = ticks_inc;
                    if (ticks_inc >= i_cfg.slow_half) begin
                        n_ticks = '0;
                        n_blink = {r_blink[4:1], ~r_blink[0]};
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_ticks = '0;
                n_blink = '0;
                n_hold  = '0;
            end
        endcase
    end

    // LED drive from the phase after this tick
    always_comb begin
        unique case (n_phase)
            PH_IDLE, PH_FAIL, PH_OK: o_led = !n_blink[0];
            PH_OPEN:                 o_led = 1'b1;
            default:                 o_led = 1'b0;
        endcase
    end

    assign o_phase = n_phase;

    // Advance the state on each processed tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_key_stable <= 1'b0;
            r_db_cnt     <= 8'd0;
            r_ticks      <= '0;
            r_hold       <= '0;
            r_tally      <= 8'd0;
            r_blink      <= 5'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_key_stable <= n_key_stable;
            r_db_cnt     <= n_db_cnt;
            r_ticks      <= n_ticks;
            r_hold       <= n_hold;
            r_tally      <= n_tally;
            r_blink      <= n_blink;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/press_count_code_lock.sv @@
// Top level of the press count code lock: input word register, lock core,
// output word register. Depends on pcl_pkg, pcl_cfg and pcl_core.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  s       | in        | i_s_tvalid/o_s_tready| i_s_tdata[0] key_pressed
//  m       | out       | o_m_tvalid/i_m_tready| o_m_tdata[0] led_lit, [3:1] phase
//  cfg     | in        | i_cfg_we             | i_cfg_idx, i_cfg_wdata
//
// One word per cycle sustained while the output is not stalled; each tick word
// passes the input register, then the core logic into the output register.
// Synchronous reset puts the lock in idle, key released, configuration at its
// defaults. While the output is stalled the input register still takes one
// word, then ready drops until the output moves.
`default_nettype none

module press_count_code_lock
    import pcl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // [0] key_pressed, [7:1] zero
    input  wire logic [7:0]            i_s_tdata,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // [0] led_lit, [3:1] phase, [7:4] zero
    output logic [7:0]                 o_m_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg   cfg;
    logic   r_in_valid;
    logic   r_in_key;
    logic   r_out_valid;
    logic   r_out_led;
    t_phase r_out_phase;
    logic   step;
    logic   core_led;
    t_phase core_phase;

    // Process the held word when the output slot is free or draining
    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    pcl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pcl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_key   (r_in_key),
        .i_cfg   (cfg),
        .o_led   (core_led),
        .o_phase (core_phase)
    );

    // Hold the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_key <= i_s_tdata[0];
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_led   <= core_led;
            r_out_phase <= core_phase;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_phase, r_out_led};

endmodule

`default_nettype wire

@@ verif/lock_checker.sv @@
`timescale 1ns / 1ps
// Checker for the press count code lock: watches the tick, result and config
// channels, predicts each result word and compares it. Depends on pcl_pkg.
module lock_checker
    import pcl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // [0] key_pressed, [7:1] zero
    input  wire logic [7:0]            i_s_tdata,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // [0] led_lit, [3:1] phase, [7:4] zero
    input  wire logic [7:0]            i_m_tdata,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                         o_pending,
    output int                         o_fail_count
);

    typedef struct packed {
        logic   led;
        t_phase phase;
    } t_lock_word;

    localparam logic [TICK_W-1:0] TICK_FULL = '1;

    // Configuration as written, masked to register width
    logic [7:0]  cf_target;
    logic [15:0] cf_window;
    logic [15:0] cf_hold;
    logic [7:0]  cf_debounce;
    logic [15:0] cf_slow;
    logic [15:0] cf_quick;
    logic [3:0]  cf_fail;
    logic [3:0]  cf_ok;

    // Predicted lock state
    t_phase            lk_phase;
    logic              key_level;
    logic [7:0]        bounce_cnt;
    logic [TICK_W-1:0] phase_cnt;
    logic [TICK_W-1:0] hold_cnt;
    logic [7:0]        tally;
    logic [4:0]        halves;

    t_lock_word led_phase_due[$];
    int         errs = 0;

    // Time register to tick limit: zero counts as one, clamp to counter range
    function automatic logic [TICK_W-1:0] ticks_cap(input logic [15:0] v);
        if (v == 16'd0) begin
            return TICK_W'(1);
        end
        if (32'(v) > 32'(TICK_FULL)) begin
            return TICK_FULL;
        end
        return TICK_W'(v);
    endfunction

    function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
        return (v == TICK_FULL) ? v : v + 1'b1;
    endfunction

    // Half periods shown for a blink count, zero counts as one blink
    function automatic logic [4:0] halves_for(input logic [3:0] n);
        return (n == 4'd0) ? 5'd2 : {n, 1'b0};
    endfunction

    task automatic go_phase(input t_phase p);
        lk_phase  = p;
        phase_cnt = '0;
        halves    = '0;
        hold_cnt  = '0;
    endtask

    task automatic reset_lock();
        cf_target   = 8'd5;
        cf_window   = 16'd5000;
        cf_hold     = 16'd3000;
        cf_debounce = 8'd20;
        cf_slow     = 16'd500;
        cf_quick    = 16'd200;
        cf_fail     = 4'd10;
        cf_ok       = 4'd3;
        go_phase(PH_IDLE);
        key_level  = 1'b0;
        bounce_cnt = '0;
        tally      = '0;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PRESS_TARGET: cf_target   = val[7:0];
            REG_ENTRY_WINDOW: cf_window   = val;
            REG_HOLD_TO_LOCK: cf_hold     = val;
            REG_DEBOUNCE:     cf_debounce = val[7:0];
            REG_SLOW_HALF:    cf_slow     = val;
            REG_QUICK_HALF:   cf_quick    = val;
            REG_FAIL_BLINKS:  cf_fail     = val[3:0];
            REG_OK_BLINKS:    cf_ok       = val[3:0];
            default: ;
        endcase
    endtask

    // Advance the lock by one tick and give the word it shows afterwards
    task automatic step_lock(input logic raw, output t_lock_word word);
        logic       press_ev;
        logic       release_ev;
        logic [7:0] db_need;
        press_ev   = 1'b0;
        release_ev = 1'b0;
        db_need    = (cf_debounce == 8'd0) ? 8'd1 : cf_debounce;

        // Debounce: a new level must persist db_need ticks
        if (raw != key_level) begin
            bounce_cnt = bounce_cnt + 8'd1;
            if (bounce_cnt >= db_need) begin
                key_level  = raw;
                bounce_cnt = '0;
                press_ev   = raw;
                release_ev = !raw;
            end
        end else begin
            bounce_cnt = '0;
        end

        case (lk_phase)
            PH_ENTER: begin
                // Bit 0 of halves marks the window as open
                if (!halves[0]) begin
                    if (release_ev) begin
                        halves    = 5'd1;
                        phase_cnt = '0;
                    end
                end else begin
                    if (release_ev && tally != 8'hFF) begin
                        tally = tally + 8'd1;
                    end
                    phase_cnt = sat_inc(phase_cnt);
                    if (phase_cnt >= ticks_cap(cf_window)) begin
                        go_phase(tally == cf_target ? PH_OK : PH_FAIL);
                    end
                end
            end
            PH_FAIL, PH_OK: begin
                phase_cnt = sat_inc(phase_cnt);
                if (phase_cnt >= ticks_cap(cf_quick)) begin
                    phase_cnt = '0;
                    halves    = halves + 5'd1;
                    if (halves >= halves_for(lk_phase == PH_FAIL ? cf_fail : cf_ok)) begin
                        go_phase(lk_phase == PH_FAIL ? PH_IDLE : PH_OPEN);
                    end
                end
            end
            PH_OPEN: begin
                if (key_level) begin
                    hold_cnt = sat_inc(hold_cnt);
                    if (hold_cnt >= ticks_cap(cf_hold)) begin
                        go_phase(PH_PAUSE);
                    end
                end else begin
                    hold_cnt = '0;
                end
            end
            PH_PAUSE: begin
                phase_cnt = sat_inc(phase_cnt);
                if (phase_cnt >= ticks_cap(cf_quick)) begin
                    go_phase(PH_IDLE);
                end
            end
            PH_IDLE: begin
                if (press_ev) begin
                    go_phase(PH_ENTER);
                    tally = 8'd1;
                end else begin
                    phase_cnt = sat_inc(phase_cnt);
                    if (phase_cnt >= ticks_cap(cf_slow)) begin
                        phase_cnt = '0;
                        halves[0] = !halves[0];
                    end
                end
            end
            default: go_phase(PH_IDLE);
        endcase

        word.phase = lk_phase;
        case (lk_phase)
            PH_IDLE, PH_FAIL, PH_OK: word.led = !halves[0];
            PH_OPEN:                 word.led = 1'b1;
            default:                 word.led = 1'b0;
        endcase
    endtask

    // Compare result words, then predict for newly taken tick words
    always @(posedge i_clk) begin
        t_lock_word due;
        if (!i_rst_n) begin
            reset_lock();
            led_phase_due.delete();
        end else begin
            if (i_cfg_we) begin
                write_cfg(i_cfg_idx, i_cfg_wdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (led_phase_due.size() == 0) begin
                    $error("result word %02h with nothing expected", i_m_tdata);
                    errs++;
                end else begin
                    due = led_phase_due.pop_front();
                    if (i_m_tdata[0] !== due.led) begin
                        $error("led_lit: expected %0d, got %0d", due.led, i_m_tdata[0]);
                        errs++;
                    end
                    if (i_m_tdata[3:1] !== 3'(due.phase)) begin
                        $error("phase: expected %0d, got %0d", due.phase, i_m_tdata[3:1]);
                        errs++;
                    end
                    if (i_m_tdata[7:4] !== 4'd0) begin
                        $error("tdata pad: expected 0, got %0h", i_m_tdata[7:4]);
                        errs++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_lock(i_s_tdata[0], due);
                led_phase_due.push_back(due);
            end
        end
        o_pending    <= led_phase_due.size();
        o_fail_count <= errs;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the press count code lock: clock, reset, tick stimulus,
// config writes and result sink. Depends on pcl_pkg, the lock and lock_checker.
module tb_top;
    import pcl_pkg::*;

    localparam int          NUM_REGS      = 8;
    localparam int unsigned RANDOM_TICKS  = 60;
    localparam int unsigned DRAIN_GAP     = 4;
    localparam int unsigned LONG_STALL_AT = 300;
    localparam int unsigned LONG_STALL    = 200;
    localparam int unsigned QUIET_LIMIT   = 3000;
    // Key levels for the short walk through every phase
    localparam logic [20:0] DIRECTED_KEYS = 21'b000100100011010000100;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    pending;
    int                    fail_count;

    // Next register set and the effective values the stimulus plans with
    logic [CFG_DATA_W-1:0] next_regs [NUM_REGS];
    int unsigned eff_target, eff_window, eff_hold, eff_db, eff_quick, eff_slow;
    int unsigned blink_max;
    int unsigned ticks_sent = 0;
    bit          tx_gaps_on = 1'b1;

    press_count_code_lock u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    lock_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned one_if_zero(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Stage a register set; narrow registers only keep their low bits
    function automatic void set_regs(input logic [15:0] target, window, hold, db,
                                     slow, quick, fail_n, ok_n);
        next_regs[REG_PRESS_TARGET] = target;
        next_regs[REG_ENTRY_WINDOW] = window;
        next_regs[REG_HOLD_TO_LOCK] = hold;
        next_regs[REG_DEBOUNCE]     = db;
        next_regs[REG_SLOW_HALF]    = slow;
        next_regs[REG_QUICK_HALF]   = quick;
        next_regs[REG_FAIL_BLINKS]  = fail_n;
        next_regs[REG_OK_BLINKS]    = ok_n;
        eff_target = target[7:0];
        eff_window = one_if_zero(window);
        eff_hold   = one_if_zero(hold);
        eff_db     = one_if_zero(db[7:0]);
        eff_slow   = one_if_zero(slow);
        eff_quick  = one_if_zero(quick);
        blink_max  = one_if_zero(fail_n[3:0]);
        if (one_if_zero(ok_n[3:0]) > blink_max) begin
            blink_max = one_if_zero(ok_n[3:0]);
        end
    endfunction

    // Random small settings, sometimes zeros and junk above narrow registers
    function automatic void pick_settings();
        logic [15:0] target, window, hold, db, slow, quick, fail_n, ok_n;
        target = 16'($urandom_range(0, 6));
        db     = 16'($urandom_range(1, 4));
        window = 16'((target + 2) * (3 * db + 6) + $urandom_range(0, 10));
        hold   = 16'($urandom_range(1, 12));
        slow   = 16'($urandom_range(1, 6));
        quick  = 16'($urandom_range(1, 4));
        fail_n = ($urandom_range(0, 7) == 0) ? 16'd15 : 16'($urandom_range(0, 4));
        ok_n   = ($urandom_range(0, 7) == 0) ? 16'd15 : 16'($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) db = '0;
        if ($urandom_range(0, 9) == 0) hold = '0;
        if ($urandom_range(0, 9) == 0) slow = '0;
        if ($urandom_range(0, 9) == 0) quick = '0;
        if ($urandom_range(0, 19) == 0) window = '0;
        if ($urandom_range(0, 3) == 0) begin
            target[15:8] = 8'($urandom);
            db[15:8]     = 8'($urandom);
            fail_n[15:4] = 12'($urandom);
            ok_n[15:4]   = 12'($urandom);
        end
        set_regs(target, window, hold, db, slow, quick, fail_n, ok_n);
    endfunction

    // Offer one tick word after a random gap and hold it until taken
    task automatic send_tick(input logic key);
        int unsigned gap;
        if (ticks_sent % 40 == 0) begin
            tx_gaps_on = ($urandom_range(0, 2) != 0);
        end
        gap = tx_gaps_on ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {7'd0, key};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic key_run(input logic level, input int unsigned n);
        repeat (n) send_tick(level);
    endtask

    // Stop sending and wait until every result word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic apply_settings();
        int i;
        drain();
        for (i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= CFG_IDX_W'(i);
            cfg_wdata <= next_regs[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Key in a code of some presses, some with contact bounce, then let the window close
    task automatic enter_code(input int unsigned presses);
        int unsigned i;
        for (i = 0; i < presses; i++) begin
            if (eff_db > 1 && $urandom_range(0, 3) == 0) begin
                key_run(1'b1, $urandom_range(1, eff_db - 1));
                key_run(1'b0, 1);
            end
            key_run(1'b1, eff_db + $urandom_range(0, 2));
            key_run(1'b0, eff_db + $urandom_range(0, 2));
        end
        key_run(1'b0, eff_window + $urandom_range(1, 4));
    endtask

    // Sit out the blinks, then hold to relock, sometimes letting go too early
    task automatic try_relock();
        key_run(1'b0, 2 * blink_max * eff_quick + $urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0) begin
            key_run(1'b1, eff_db + $urandom_range(0, eff_hold));
        end else begin
            key_run(1'b1, eff_db + eff_hold + $urandom_range(0, 3));
        end
        key_run(1'b0, eff_db + eff_quick + $urandom_range(0, 4));
        if ($urandom_range(0, 1) == 0) begin
            key_run(1'b0, $urandom_range(0, 2 * eff_slow));
        end
    endtask

    task automatic key_noise(input int unsigned n);
        repeat (n) send_tick(1'($urandom_range(0, 1)));
    endtask

    initial begin : stimulus
        int          i;
        int unsigned rand_start;
        int unsigned presses;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, then a quick walk through every phase
        key_run(1'b1, 2);
        key_run(1'b0, 2);
        set_regs(2, 3, 0, 0, 2, 0, 0, 1);
        apply_settings();
        for (i = 20; i >= 0; i--) begin
            send_tick(DIRECTED_KEYS[i]);
        end

        // All registers at their lowest
        set_regs(0, 1, 1, 1, 1, 1, 1, 1);
        apply_settings();
        key_noise(20);
        enter_code(1);
        try_relock();

        // All registers at their highest: a press far shorter than the debounce time
        set_regs(255, 16'hFFFF, 16'hFFFF, 255, 16'hFFFF, 16'hFFFF, 15, 15);
        apply_settings();
        key_run(1'b1, 12);
        key_run(1'b0, 2);

        // Tally saturation: more than 255 presses inside one window
        set_regs(255, 520, 4, 1, 3, 1, 1, 1);
        apply_settings();
        repeat (262) begin
            send_tick(1'b1);
            send_tick(1'b0);
        end
        key_run(1'b0, 10);
        try_relock();

        // Random sessions, mostly well-formed code entries
        rand_start = ticks_sent;
        while (ticks_sent < rand_start + RANDOM_TICKS) begin
            pick_settings();
            apply_settings();
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(0, 9) < 2) begin
                    key_noise($urandom_range(5, 30));
                end else begin
                    if (eff_target != 0 && $urandom_range(0, 9) < 6) begin
                        presses = eff_target;
                    end else begin
                        presses = $urandom_range(1, eff_target + 2);
                    end
                    enter_code(presses);
                    try_relock();
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result sink: random stalls, stretches without, one long hold-off
    initial begin : result_sink
        int unsigned taken;
        int unsigned gap;
        bit          gaps_on;
        taken   = 0;
        gaps_on = 1'b1;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        m_tready <= 1'b1;
        forever begin
            @(posedge clk);
            if (m_tready && m_tvalid) begin
                taken++;
                if (taken % 40 == 0) begin
                    gaps_on = ($urandom_range(0, 2) != 0);
                end
                gap = gaps_on ? $urandom_range(0, 18) : 0;
                if (taken == LONG_STALL_AT) begin
                    gap = LONG_STALL;
                end
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: give up when no word moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
